// ===== hw/rtl/dhtb_pkg.sv =====
// ----------------------------------------------------------------------------
// dhtb_pkg
// Shared types, codes and functions of the dictionary hash table builder:
// hash and tag functions, entry packing, controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package dhtb_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = 10;
    localparam int ENTRY_W       = 64;
    localparam int POS_W         = 12;
    localparam int TAG_W         = 4;
    localparam int COUNT_W       = 13;
    localparam int WIN_W         = 40;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 12;
    localparam int STEP_W        = 2;
    localparam int NUM_STEPS     = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_POINTER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_OFFSET   = 2'd1;

    localparam logic [IDX_W-1:0] BIT_HASH [24] = '{
        10'h001, 10'h002, 10'h004, 10'h008, 10'h010, 10'h020, 10'h040, 10'h080,
        10'h100, 10'h200, 10'h009, 10'h012, 10'h024, 10'h048, 10'h090, 10'h120,
        10'h240, 10'h089, 10'h112, 10'h224, 10'h041, 10'h082, 10'h104, 10'h208
    };

    typedef struct packed {
        logic              accept_byte;
        logic              accept_read;
        logic              accept_clear;
        logic              sel_entry;
        logic              ram_we;
        logic              clear_we;
        logic              out_load;
        logic [STEP_W-1:0] step;
        logic [IDX_W-1:0]  clr_addr;
    } dhtb_cmd_t;

    typedef struct packed {
        logic [NUM_STEPS-1:0] step_en;
    } dhtb_status_t;

    function automatic logic [IDX_W-1:0] hash24(input logic [23:0] w);
        logic [IDX_W-1:0] h;
        h = '0;
        for (int b = 0; b < 24; b++) begin
            if (w[b]) begin
                h = h ^ BIT_HASH[b];
            end
        end
        return h;
    endfunction

    function automatic logic [TAG_W-1:0] parity_tag(input logic [15:0] d_in);
        logic [15:0] d;
        d = d_in;
        d = d ^ (d >> 4);
        d = d ^ (d >> 2);
        return {d[9:8], d[1:0]};
    endfunction

    function automatic logic [ENTRY_W-1:0] pack_entry(input logic [ENTRY_W-1:0] e,
                                                      input logic four_mode);
        logic [31:0]        v;
        logic [31:0]        p2;
        logic [ENTRY_W-1:0] p4;
        v  = e[31:0];
        p2 = (v & 32'h0000000F) | ((v >> 12) & 32'h000000F0) |
             ((v << 4) & 32'h000FFF00) | (v & 32'hFFF00000);
        p4 = (e & 64'h000000000000000F) |
             ((e >> 12) & 64'h00000000000000F0) |
             ((e >> 24) & 64'h0000000000000F00) |
             ((e >> 36) & 64'h000000000000F000) |
             ((e << 12) & 64'h000000000FFF0000) |
             ((e << 8)  & 64'h000000FFF0000000) |
             ((e << 4)  & 64'h000FFF0000000000) |
             (e & 64'hFFF0000000000000);
        return four_mode ? p4 : {32'd0, p2};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dhtb_ram.sv =====
// ----------------------------------------------------------------------------
// dhtb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dhtb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dhtb_datapath.sv =====
// ----------------------------------------------------------------------------
// dhtb_datapath
// Byte window, byte count, configuration, slot forming, table RAM and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dhtb_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire dhtb_pkg::dhtb_cmd_t                 cmd,
    output dhtb_pkg::dhtb_status_t                   status,
    input  wire logic [7:0]                          s_data_byte,
    input  wire logic                                s_last_byte,
    input  wire logic [dhtb_pkg::IDX_W-1:0]          s_entry_index,
    input  wire logic                                cfg_write,
    input  wire logic [dhtb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dhtb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic      [dhtb_pkg::ENTRY_W-1:0]        m_packed_entry
);

    logic                            mode_reg;
    logic [dhtb_pkg::POS_W-1:0]      offset_reg;
    logic [dhtb_pkg::WIN_W-1:0]      win_reg;
    logic [dhtb_pkg::COUNT_W-1:0]    count_reg;
    logic [dhtb_pkg::COUNT_W-1:0]    c_reg;
    logic                            last_reg;
    logic [dhtb_pkg::IDX_W-1:0]      idx_reg;
    logic [dhtb_pkg::ENTRY_W-1:0]    out_data_reg;

    logic [23:0]                     key;
    logic [dhtb_pkg::TAG_W-1:0]      tag;
    logic [dhtb_pkg::POS_W-1:0]      pos;
    logic [2:0]                      back;
    logic [dhtb_pkg::IDX_W-1:0]      hash_addr;
    logic [dhtb_pkg::IDX_W-1:0]      raddr;
    logic [dhtb_pkg::IDX_W-1:0]      waddr;
    logic [dhtb_pkg::ENTRY_W-1:0]    wdata;
    logic [dhtb_pkg::ENTRY_W-1:0]    rdata;
    logic                            we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            offset_reg <= '0;
            win_reg    <= '0;
            count_reg  <= '0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    dhtb_pkg::CFG_FOUR_POINTER_MODE: mode_reg   <= cfg_data[0];
                    dhtb_pkg::CFG_POSITION_OFFSET:   offset_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.accept_byte) begin
                win_reg <= {win_reg[31:0], s_data_byte};
                if (count_reg != dhtb_pkg::COUNT_MAX) begin
                    count_reg <= count_reg + 1'b1;
                end
            end else if (cmd.accept_clear) begin
                win_reg   <= '0;
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept_byte) begin
            c_reg    <= count_reg;
            last_reg <= s_last_byte;
        end
        if (cmd.accept_read) begin
            idx_reg <= s_entry_index;
        end
        if (cmd.out_load) begin
            out_data_reg <= dhtb_pkg::pack_entry(rdata, mode_reg);
        end
    end

    always_comb begin
        case (cmd.step)
            2'd0: begin
                key = {win_reg[23:16], win_reg[31:24], win_reg[39:32]};
                tag = dhtb_pkg::parity_tag({win_reg[7:0], win_reg[15:8]});
            end
            2'd1: begin
                key = {win_reg[15:8], win_reg[23:16], win_reg[31:24]};
                tag = '0;
            end
            2'd2: begin
                key = {win_reg[7:0], win_reg[15:8], win_reg[23:16]};
                tag = '0;
            end
            default: begin
                key = '0;
                tag = '0;
            end
        endcase
    end

    assign back      = 3'd4 - {1'b0, cmd.step};
    assign pos       = c_reg[dhtb_pkg::POS_W-1:0] + offset_reg - {9'd0, back};
    assign hash_addr = dhtb_pkg::hash24(key);

    assign status.step_en[0] = (c_reg >= 13'd4);
    assign status.step_en[1] = last_reg && (c_reg >= 13'd3);
    assign status.step_en[2] = last_reg && (c_reg >= 13'd2);

    assign raddr = cmd.sel_entry ? idx_reg : hash_addr;
    assign we    = cmd.ram_we | cmd.clear_we;
    assign waddr = cmd.clear_we ? cmd.clr_addr : hash_addr;
    assign wdata = cmd.clear_we ? '0 : {rdata[47:0], pos, tag};

    dhtb_ram #(
        .WIDTH (dhtb_pkg::ENTRY_W),
        .DEPTH (dhtb_pkg::TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign m_packed_entry = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dhtb_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhtb_ctrl
// Controller: input handshake, table clearing sweep, read-modify-write
// sequencing of the three slot updates, result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module dhtb_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [dhtb_pkg::KIND_W-1:0]   s_kind,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    input  wire dhtb_pkg::dhtb_status_t        status,
    output dhtb_pkg::dhtb_cmd_t                cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_FETCH = 3'd4;
    localparam logic [2:0] ST_RESP  = 3'd5;

    localparam logic [dhtb_pkg::STEP_W-1:0] LAST_STEP =
        dhtb_pkg::STEP_W'(dhtb_pkg::NUM_STEPS - 1);

    logic [2:0]                       state_reg, state_next;
    logic [dhtb_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [dhtb_pkg::IDX_W-1:0]       clr_reg, clr_next;
    logic                             m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            step_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        clr_next   = clr_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.step     = step_reg;
        cmd.clr_addr = clr_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_we = 1'b1;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == dhtb_pkg::LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_kind)
                        dhtb_pkg::KIND_BYTE: begin
                            cmd.accept_byte = 1'b1;
                            step_next       = '0;
                            state_next      = ST_READ;
                        end
                        dhtb_pkg::KIND_READ: begin
                            cmd.accept_read = 1'b1;
                            state_next      = ST_FETCH;
                        end
                        dhtb_pkg::KIND_CLEAR: begin
                            cmd.accept_clear = 1'b1;
                            clr_next         = '0;
                            state_next       = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (status.step_en[step_reg]) begin
                    state_next = ST_WRITE;
                end else if (step_reg == LAST_STEP) begin
                    state_next = ST_IDLE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_WRITE: begin
                cmd.ram_we = 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_IDLE;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_FETCH: begin
                cmd.sel_entry = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RESP: begin
                cmd.sel_entry = 1'b1;
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dictionary_hash_table_builder_top.sv =====
// ----------------------------------------------------------------------------
// dictionary_hash_table_builder_top
// Builds the 1024-entry hash chain table of a compression dictionary and
// returns packed entries on request.
// ----------------------------------------------------------------------------
// Operation: after reset, and after every clear item, the table is zeroed by a
// sweep over all 1024 entries during which no input item is accepted
// (configuration writes are taken at any time). A byte item is first taken;
// then each of the three slot steps does a table read, and each slot that is
// updated also gets a write (a read-modify-write of the table RAM), so a byte
// updates 0 to 3 slots: an ordinary byte at most one, a final byte up to three.
// A read item is taken, the RAM is read and the result is loaded once the
// output register is free; it is then held in the output register until taken.
// A clear item is taken and then starts the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module dictionary_hash_table_builder_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [dhtb_pkg::KIND_W-1:0]         s_kind,
    input  wire logic [7:0]                          s_data_byte,
    input  wire logic                                s_last_byte,
    input  wire logic [dhtb_pkg::IDX_W-1:0]          s_entry_index,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [dhtb_pkg::ENTRY_W-1:0]        m_packed_entry,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [dhtb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dhtb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dhtb_pkg::dhtb_cmd_t    cmd;
    dhtb_pkg::dhtb_status_t status;

    assign cfg_ready = 1'b1;

    dhtb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dhtb_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .s_entry_index  (s_entry_index),
        .cfg_write      (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_packed_entry (m_packed_entry)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/dhtb_checker.sv =====
// ----------------------------------------------------------------------------
// dhtb_checker
// Port-level checks of the dictionary hash table builder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dhtb_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic [dhtb_pkg::KIND_W-1:0]         s_kind,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic [dhtb_pkg::ENTRY_W-1:0]        m_packed_entry
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packed_entry))
        else $error("result changed while stalled");

    a_byte_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == dhtb_pkg::KIND_BYTE |=> !$rose(m_valid))
        else $error("byte transfer produced a result");

    a_read_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == dhtb_pkg::KIND_READ ||
        s_kind == dhtb_pkg::KIND_CLEAR) |=> !s_ready)
        else $error("input taken while a read or clear is in progress");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("handshake outputs active after reset");

endmodule

bind dictionary_hash_table_builder_top dhtb_checker u_dhtb_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_kind         (s_kind),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_packed_entry (m_packed_entry)
);

`default_nettype wire
